@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define AST_HOLD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence starting in the next
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> cons) else $error(msg);

`endif

@@ src/acucp_pkg.sv @@
// Types, constants and decode tables of the audio controller config port
package acucp_pkg;

    localparam logic [15:0] PORT_INDEX = 16'hF86;
    localparam logic [15:0] PORT_DATA  = 16'hF87;
    localparam logic [7:0]  UNLOCK_KEY = 8'h1D;

    localparam logic [7:0] IDX_CODEC  = 8'd1;
    localparam logic [7:0] IDX_LEGACY = 8'd2;
    localparam logic [7:0] IDX_MIDI   = 8'd3;
    localparam logic [7:0] IDX_RSV_A  = 8'd4;
    localparam logic [7:0] IDX_RSV_B  = 8'd5;

    localparam logic [1:0] CPORT_CFG    = 2'd0;
    localparam logic [1:0] CPORT_STATUS = 2'd3;

    localparam logic [7:0] RD_NONE = 8'hFF;

    typedef struct packed {
        logic        is_write;
        logic [15:0] addr;
        logic [7:0]  wr_data;
    } t_item;

    typedef struct packed {
        logic       open;
        logic [7:0] reg_index;
        logic [7:0] set_codec;
        logic [7:0] set_legacy;
        logic [7:0] set_midi;
        logic [7:0] codec_cfg;
        logic [3:0] codec_irq;
        logic [1:0] codec_dma;
        logic [3:0] legacy_irq;
        logic [3:0] midi_irq;
    } t_state;

    // packed from the top bit down, so rd_data lands in the low byte
    typedef struct packed {
        logic        gameport_on;
        logic [3:0]  mpu_irq;
        logic [11:0] mpu_base;
        logic [2:0]  sb_dma;
        logic [3:0]  sb_irq;
        logic [11:0] sb_base;
        logic [1:0]  wss_dma;
        logic [3:0]  wss_irq;
        logic        wss_enabled;
        logic [11:0] wss_base;
        logic        access_open;
        logic [7:0]  rd_data;
    } t_result;

    localparam t_state STATE_RESET = '{
        open:       1'b0,
        reg_index:  8'h00,
        set_codec:  8'h24,
        set_legacy: 8'h46,
        set_midi:   8'h87,
        codec_cfg:  8'h00,
        codec_irq:  4'd11,
        codec_dma:  2'd0,
        legacy_irq: 4'd5,
        midi_irq:   4'd9
    };

    function automatic logic [11:0] wss_base_of(input logic [1:0] sel);
        case (sel)
            2'd0:    wss_base_of = 12'h530;
            2'd1:    wss_base_of = 12'hE80;
            2'd2:    wss_base_of = 12'hF40;
            default: wss_base_of = 12'h604;
        endcase
    endfunction

    function automatic logic [11:0] mpu_base_of(input logic [1:0] sel);
        case (sel)
            2'd0:    mpu_base_of = 12'h330;
            2'd1:    mpu_base_of = 12'h332;
            2'd2:    mpu_base_of = 12'h334;
            default: mpu_base_of = 12'h300;
        endcase
    endfunction

    function automatic logic [2:0] sb_dma_of(input logic [1:0] sel);
        case (sel)
            2'd0:    sb_dma_of = 3'd4;
            2'd1:    sb_dma_of = 3'd0;
            2'd2:    sb_dma_of = 3'd1;
            default: sb_dma_of = 3'd3;
        endcase
    endfunction

    function automatic logic [1:0] codec_dma_of(input logic [1:0] sel);
        case (sel)
            2'd2:    codec_dma_of = 2'd1;
            2'd3:    codec_dma_of = 2'd3;
            default: codec_dma_of = 2'd0;
        endcase
    endfunction

    function automatic logic [3:0] codec_irq_of(input logic [2:0] sel);
        case (sel)
            3'd1:    codec_irq_of = 4'd7;
            3'd2:    codec_irq_of = 4'd9;
            3'd3:    codec_irq_of = 4'd10;
            3'd4:    codec_irq_of = 4'd11;
            default: codec_irq_of = 4'd0;
        endcase
    endfunction

endpackage

@@ src/acucp_step.sv @@
// Combinational decode of one I/O access: next settings and result item
module acucp_step (
    input  acucp_pkg::t_state  i_st,
    input  acucp_pkg::t_item   i_item,
    output acucp_pkg::t_state  o_nxt,
    output acucp_pkg::t_result o_res
);
    import acucp_pkg::*;

    logic       is_idx;
    logic       is_dat;
    logic       codec_hit;
    logic [1:0] cport;
    logic [7:0] rd;
    logic [7:0] setting_rd;
    logic [11:0] cur_base;
    t_state     nxt;

    assign cur_base  = wss_base_of(i_st.set_codec[4:3]);
    assign is_idx    = (i_item.addr == PORT_INDEX);
    assign is_dat    = (i_item.addr == PORT_DATA);
    // all codec bases are 4-aligned, so the window is a match on addr[15:2]
    assign codec_hit = (i_item.addr[15:2] == {4'h0, cur_base[11:2]});
    assign cport     = i_item.addr[1:0];

    always_comb begin
        case (i_st.reg_index)
            IDX_CODEC:  setting_rd = i_st.set_codec;
            IDX_LEGACY: setting_rd = i_st.set_legacy;
            IDX_MIDI:   setting_rd = i_st.set_midi;
            IDX_RSV_A,
            IDX_RSV_B:  setting_rd = 8'h00;
            default:    setting_rd = RD_NONE;
        endcase
    end

    always_comb begin
        nxt = i_st;
        rd  = RD_NONE;
        if (is_idx || is_dat) begin
            if (i_item.is_write) begin
                if (i_st.open) begin
                    if (is_idx) begin
                        nxt.reg_index = i_item.wr_data;
                    end else begin
                        nxt.open = 1'b0;
                        case (i_st.reg_index)
                            IDX_CODEC: begin
                                nxt.set_codec = i_item.wr_data;
                            end
                            IDX_LEGACY: begin
                                nxt.set_legacy = i_item.wr_data;
                                case (i_item.wr_data[4:2])
                                    3'd0:    nxt.legacy_irq = 4'd0;
                                    3'd1:    nxt.legacy_irq = 4'd5;
                                    3'd2:    nxt.legacy_irq = 4'd7;
                                    3'd3:    nxt.legacy_irq = 4'd9;
                                    3'd4:    nxt.legacy_irq = 4'd10;
                                    3'd5:    nxt.legacy_irq = 4'd11;
                                    default: nxt.legacy_irq = i_st.legacy_irq;
                                endcase
                            end
                            IDX_MIDI: begin
                                nxt.set_midi = i_item.wr_data;
                                case (i_item.wr_data[4:2])
                                    3'd0:    nxt.midi_irq = 4'd0;
                                    3'd1:    nxt.midi_irq = 4'd5;
                                    3'd2:    nxt.midi_irq = 4'd7;
                                    3'd3:    nxt.midi_irq = 4'd9;
                                    3'd4:    nxt.midi_irq = 4'd10;
                                    default: nxt.midi_irq = i_st.midi_irq;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end else if (is_idx && i_item.wr_data == UNLOCK_KEY) begin
                    nxt.open = 1'b1;
                end
            end else if (i_st.open) begin
                if (is_idx) begin
                    rd = i_st.reg_index;
                end else begin
                    rd       = setting_rd;
                    nxt.open = 1'b0;
                end
            end
        end else if (codec_hit) begin
            if (i_item.is_write) begin
                if (cport == CPORT_CFG) begin
                    nxt.codec_cfg = i_item.wr_data;
                    nxt.codec_dma = codec_dma_of(i_item.wr_data[1:0]);
                    nxt.codec_irq = codec_irq_of(i_item.wr_data[5:3]);
                end
            end else if (cport == CPORT_STATUS) begin
                rd = 8'h04 | (i_st.codec_cfg & 8'h40);
            end else begin
                rd = i_st.codec_cfg;
            end
        end
        if (i_item.is_write) begin
            rd = 8'h00;
        end
    end

    assign o_nxt = nxt;

    always_comb begin
        o_res.rd_data     = rd;
        o_res.access_open = nxt.open;
        o_res.wss_base    = wss_base_of(nxt.set_codec[4:3]);
        o_res.wss_enabled = nxt.set_codec[5];
        o_res.wss_irq     = nxt.codec_irq;
        o_res.wss_dma     = nxt.codec_dma;
        o_res.sb_base     = nxt.set_legacy[5] ? 12'h240 : 12'h220;
        o_res.sb_irq      = nxt.legacy_irq;
        o_res.sb_dma      = sb_dma_of(nxt.set_legacy[1:0]);
        o_res.mpu_base    = mpu_base_of(nxt.set_midi[6:5]);
        o_res.mpu_irq     = nxt.midi_irq;
        o_res.gameport_on = nxt.set_midi[0];
    end

endmodule

@@ src/acucp_state.sv @@
// Settings registers of the config port, updated once per processed item
`include "assert_macros.svh"

module acucp_state (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  acucp_pkg::t_item   i_item,
    output acucp_pkg::t_result o_res
);
    import acucp_pkg::*;

    t_state r_st;
    t_state n_st;

    acucp_step u_step (
        .i_st   (r_st),
        .i_item (i_item),
        .o_nxt  (n_st),
        .o_res  (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    // a data-port write while open always relocks the pair
    `AST_NEXT(a_data_wr_closes,
        i_en && r_st.open && i_item.is_write && i_item.addr == PORT_DATA,
        !r_st.open, "data write left the index pair open")
    // the key at the index port opens a locked pair
    `AST_NEXT(a_key_opens,
        i_en && !r_st.open && i_item.is_write && i_item.addr == PORT_INDEX
            && i_item.wr_data == UNLOCK_KEY,
        r_st.open, "unlock key did not open the index pair")
    `AST_HOLD(a_codec_irq_legal,
        r_st.codec_irq == 4'd0 || r_st.codec_irq == 4'd7 || r_st.codec_irq == 4'd9
            || r_st.codec_irq == 4'd10 || r_st.codec_irq == 4'd11,
        "codec IRQ outside its table")

endmodule

@@ src/audio_ctrl_unlock_config_port.sv @@
// Top level: ISA config port with locked index/data pair, stream in and out
//
//  channel | direction | tdata                              | tuser     | tlast
//  s_*     | in        | addr[15:0], wr_data[23:16]         | req_type  | -
//  m_*     | out       | result fields, 64 bits (see port)  | -         | -
//
//  From acceptance to result an item passes the input register, then the
//  decode and settings update into the result register.
//  One item per clock is sustained while the output is ready; the settings
//  registers update in the cycle an item moves into the result register.
//  A stalled result holds in the output register while one more item waits
//  in the input register; the input side stalls only when both are full.
//  Reset (synchronous, active low) empties both registers and restores the
//  power-on settings.
`include "assert_macros.svh"

module audio_ctrl_unlock_config_port (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // addr[15:0], wr_data[23:16]
    input  logic        i_s_tuser,   // req_type (1 write, 0 read)
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // rd_data[7:0], access_open[8], wss_base[20:9], wss_enabled[21],
    // wss_irq[25:22], wss_dma[27:26], sb_base[39:28], sb_irq[43:40],
    // sb_dma[46:44], mpu_base[58:47], mpu_irq[62:59], gameport_on[63]
    output logic [63:0] o_m_tdata
);
    import acucp_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    advance;
    logic    s_fire;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in.is_write <= i_s_tuser;
            r_in.addr     <= i_s_tdata[15:0];
            r_in.wr_data  <= i_s_tdata[23:16];
        end
    end

    acucp_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // an item entering an empty pipe shows up as a result after the input and result registers
    `AST_NEXT(a_empty_latency, s_fire && !r_in_valid && !r_out_valid,
        ##1 o_m_tvalid, "item into empty pipe did not reach the output")
    // the input side only stalls with both stages holding items
    `AST_HOLD(a_stall_full, o_s_tready || (r_in_valid && r_out_valid),
        "input stalled with a free stage")

endmodule
